### src/bnb_pkg.sv
package bnb_pkg;

    localparam int CHANNELS_DEF = 64;
    localparam int CFG_IDX_W    = 1;
    localparam int CFG_DATA_W   = 25;

    localparam logic [CFG_IDX_W-1:0] CFG_SAMPLE_COUNT = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TRAIN_MODE   = 1'd1;

    localparam logic [1:0] CMD_LOAD     = 2'd0;
    localparam logic [1:0] CMD_ACCUM    = 2'd1;
    localparam logic [1:0] CMD_FINALIZE = 2'd2;
    localparam logic [1:0] CMD_DX       = 2'd3;

    localparam logic [1:0] KIND_ACK  = 2'd0;
    localparam logic [1:0] KIND_GRAD = 2'd1;
    localparam logic [1:0] KIND_DX   = 2'd2;

    typedef struct packed {
        logic [1:0]         command;
        logic [5:0]         channel;
        logic signed [31:0] x_value;
        logic signed [31:0] dy_value;
        logic signed [31:0] mean_value;
        logic [30:0]        invstd_value;
        logic signed [31:0] gamma_value;
    } in_item_t;

    typedef struct packed {
        logic [1:0]         kind;
        logic [5:0]         out_channel;
        logic signed [31:0] grad_bias;
        logic signed [31:0] grad_scale;
        logic signed [31:0] grad_input;
    } out_item_t;

    typedef struct packed {
        in_item_t item;
        logic     ok;
    } job_t;

    typedef struct packed {
        logic [24:0] sample_count;
        logic        train_mode;
    } cfg_t;

endpackage

### src/bnb_front.sv
module bnb_front #(
    parameter int CHANNELS = bnb_pkg::CHANNELS_DEF
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  bnb_pkg::in_item_t s_data,
    output logic              job_valid,
    output bnb_pkg::job_t     job,
    input  logic              job_pop
);

    bnb_pkg::job_t q_reg [2];
    logic       wr_ptr_reg, rd_ptr_reg;
    logic [1:0] count_reg;
    logic       push;

    assign s_ready   = (count_reg != 2'd2);
    assign push      = s_valid && s_ready;
    assign job_valid = (count_reg != 2'd0);
    assign job       = q_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (push) begin
            q_reg[wr_ptr_reg].item <= s_data;
            q_reg[wr_ptr_reg].ok   <= ({26'd0, s_data.channel} < CHANNELS);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            if (push) wr_ptr_reg <= ~wr_ptr_reg;
            if (job_pop) rd_ptr_reg <= ~rd_ptr_reg;
            count_reg <= count_reg + 2'(push) - 2'(job_pop);
        end
    end

endmodule

### src/bnb_mul.sv
module bnb_mul (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               start,
    input  logic signed [63:0] op_a,
    input  logic signed [63:0] op_b,
    output logic               done,
    output logic signed [63:0] result
);

    logic [63:0]  ma_reg, mb_reg;
    logic         neg_reg;
    logic [127:0] acc_reg;
    logic [63:0]  pp_reg;
    logic [1:0]   sh_reg;
    logic [2:0]   cnt_reg;
    logic         busy_reg, fin_reg, done_reg;
    logic signed [63:0] res_reg;
    logic [31:0]  a_part, b_part;
    logic [127:0] full;

    assign a_part = cnt_reg[0] ? ma_reg[63:32] : ma_reg[31:0];
    assign b_part = cnt_reg[1] ? mb_reg[63:32] : mb_reg[31:0];
    assign full   = neg_reg ? (128'd0 - acc_reg) : acc_reg;
    assign done   = done_reg;
    assign result = res_reg;

    always_ff @(posedge aclk) begin
        if (start) begin
            ma_reg  <= op_a[63] ? 64'(-op_a) : 64'(op_a);
            mb_reg  <= op_b[63] ? 64'(-op_b) : 64'(op_b);
            neg_reg <= op_a[63] ^ op_b[63];
            acc_reg <= 128'd0;
        end else if (busy_reg) begin
            if (cnt_reg != 3'd4) begin
                pp_reg <= 64'(a_part) * 64'(b_part);
                sh_reg <= 2'(cnt_reg[0]) + 2'(cnt_reg[1]);
            end
            if (cnt_reg != 3'd0) begin
                acc_reg <= acc_reg + (128'(pp_reg) << {sh_reg, 5'd0});
            end
        end
        if (fin_reg) begin
            if (full[127:79] == {49{full[79]}}) begin
                res_reg <= full[79:16];
            end else begin
                res_reg <= full[127] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg  <= 3'd0;
            busy_reg <= 1'b0;
            fin_reg  <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= fin_reg;
            fin_reg  <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= 3'd0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + 3'd1;
                if (cnt_reg == 3'd4) begin
                    busy_reg <= 1'b0;
                    fin_reg  <= 1'b1;
                end
            end
        end
    end

endmodule

### src/bnb_div.sv
module bnb_div (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               start,
    input  logic signed [63:0] dividend,
    input  logic [24:0]        divisor,
    output logic               done,
    output logic signed [63:0] quotient
);

    logic [63:0] dvd_reg;
    logic [24:0] rem_reg, dsr_reg;
    logic        neg_reg;
    logic [6:0]  cnt_reg;
    logic        busy_reg, done_reg;
    logic [25:0] rem_sh;
    logic        fit;

    assign rem_sh   = {rem_reg, dvd_reg[63]};
    assign fit      = (rem_sh >= {1'b0, dsr_reg});
    assign done     = done_reg;
    assign quotient = neg_reg ? (64'sd0 - $signed(dvd_reg)) : $signed(dvd_reg);

    always_ff @(posedge aclk) begin
        if (start) begin
            dvd_reg <= dividend[63] ? 64'(-dividend) : 64'(dividend);
            neg_reg <= dividend[63];
            dsr_reg <= divisor;
            rem_reg <= 25'd0;
        end else if (busy_reg) begin
            rem_reg <= fit ? 25'(rem_sh - {1'b0, dsr_reg}) : rem_sh[24:0];
            dvd_reg <= {dvd_reg[62:0], fit};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg  <= 7'd0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= 7'd0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + 7'd1;
                if (cnt_reg == 7'd63) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

endmodule

### src/bnb_back.sv
module bnb_back #(
    parameter int CHANNELS = bnb_pkg::CHANNELS_DEF
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  bnb_pkg::cfg_t      cfg,
    input  logic               job_valid,
    input  bnb_pkg::job_t      job,
    output logic               job_pop,
    output logic               m_valid,
    input  logic               m_ready,
    output bnb_pkg::out_item_t m_data
);

    localparam int AW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

    typedef enum logic [3:0] {
        S_IDLE, S_READ, S_ACC, S_FIN, S_DSC, S_P1, S_P2, S_T1, S_T2, S_G, S_R, S_OUT
    } state_t;

    function automatic logic signed [63:0] sat_add(input logic signed [63:0] a,
                                                   input logic signed [63:0] b);
        logic signed [64:0] s;
        s = {a[63], a} + {b[63], b};
        if (s[64] != s[63]) return s[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
        return s[63:0];
    endfunction

    function automatic logic signed [63:0] sat_sub(input logic signed [63:0] a,
                                                   input logic signed [63:0] b);
        logic signed [64:0] s;
        s = {a[63], a} - {b[63], b};
        if (s[64] != s[63]) return s[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
        return s[63:0];
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
        if (v[63:31] == {33{v[31]}}) return v[31:0];
        return v[63] ? 32'sh80000000 : 32'sh7fffffff;
    endfunction

    logic [31:0] mean_mem [CHANNELS];
    logic [30:0] inv_mem  [CHANNELS];
    logic [31:0] gam_mem  [CHANNELS];
    logic [63:0] bsum_mem [CHANNELS];
    logic [63:0] ssum_mem [CHANNELS];
    logic        vld_reg  [CHANNELS];

    state_t             state_reg;
    bnb_pkg::job_t      item_reg;
    bnb_pkg::out_item_t res_reg, out_reg;
    logic               m_valid_reg;
    logic [31:0]        mean_q, gam_q;
    logic [30:0]        inv_q;
    logic [63:0]        bsum_q, ssum_q;
    logic               vld_q;
    logic signed [63:0] p2_reg, t1_reg, d_reg;
    logic               mul_start_reg, div_start_reg;
    logic signed [63:0] mul_a_reg, mul_b_reg, div_a_reg;

    logic [AW-1:0]      rd_addr, wr_addr;
    logic signed [63:0] bsum, ssum, inv64, xm, dy64;
    logic signed [63:0] bsum_new, ssum_new;
    logic               load_we, acc_we;
    logic               mul_done, div_done;
    logic signed [63:0] mul_res, div_q;
    logic [24:0]        n_div;

    assign rd_addr  = AW'(job.item.channel);
    assign wr_addr  = AW'(item_reg.item.channel);
    assign job_pop  = (state_reg == S_IDLE) && job_valid;
    assign bsum     = vld_q ? $signed(bsum_q) : 64'sd0;
    assign ssum     = vld_q ? $signed(ssum_q) : 64'sd0;
    assign inv64    = $signed({33'd0, inv_q});
    assign dy64     = 64'(item_reg.item.dy_value);
    assign xm       = 64'(item_reg.item.x_value) - 64'($signed(mean_q));
    assign n_div    = (cfg.sample_count == 25'd0) ? 25'd1 : cfg.sample_count;
    assign bsum_new = sat_add(bsum, dy64);
    assign ssum_new = sat_add(ssum, mul_res);
    assign load_we  = (state_reg == S_READ) && item_reg.ok
                      && (item_reg.item.command == bnb_pkg::CMD_LOAD);
    assign acc_we   = (state_reg == S_ACC) && mul_done;
    assign m_valid  = m_valid_reg;
    assign m_data   = out_reg;

    bnb_mul u_mul (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (mul_start_reg),
        .op_a    (mul_a_reg),
        .op_b    (mul_b_reg),
        .done    (mul_done),
        .result  (mul_res)
    );

    bnb_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start_reg),
        .dividend (div_a_reg),
        .divisor  (n_div),
        .done     (div_done),
        .quotient (div_q)
    );

    always_ff @(posedge aclk) begin
        if (job_pop) begin
            mean_q <= mean_mem[rd_addr];
            inv_q  <= inv_mem[rd_addr];
            gam_q  <= gam_mem[rd_addr];
            bsum_q <= bsum_mem[rd_addr];
            ssum_q <= ssum_mem[rd_addr];
        end
        if (load_we) begin
            mean_mem[wr_addr] <= item_reg.item.mean_value;
            inv_mem[wr_addr]  <= item_reg.item.invstd_value;
            gam_mem[wr_addr]  <= item_reg.item.gamma_value;
            bsum_mem[wr_addr] <= 64'd0;
            ssum_mem[wr_addr] <= 64'd0;
        end else if (acc_we) begin
            bsum_mem[wr_addr] <= bsum_new;
            ssum_mem[wr_addr] <= ssum_new;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < CHANNELS; i++) vld_reg[i] <= 1'b0;
            vld_q <= 1'b0;
        end else begin
            if (job_pop) vld_q <= vld_reg[rd_addr];
            if (load_we || acc_we) vld_reg[wr_addr] <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            m_valid_reg   <= 1'b0;
            mul_start_reg <= 1'b0;
            div_start_reg <= 1'b0;
        end else begin
            mul_start_reg <= 1'b0;
            div_start_reg <= 1'b0;
            if (m_valid_reg && m_ready) m_valid_reg <= 1'b0;
            case (state_reg)
                S_IDLE: begin
                    if (job_valid) begin
                        item_reg  <= job;
                        state_reg <= S_READ;
                    end
                end
                S_READ: begin
                    res_reg.kind        <= bnb_pkg::KIND_ACK;
                    res_reg.out_channel <= item_reg.item.channel;
                    res_reg.grad_bias   <= 32'sd0;
                    res_reg.grad_scale  <= 32'sd0;
                    res_reg.grad_input  <= 32'sd0;
                    state_reg           <= S_OUT;
                    case (item_reg.item.command)
                        bnb_pkg::CMD_LOAD: begin
                        end
                        bnb_pkg::CMD_ACCUM: begin
                            if (item_reg.ok) begin
                                mul_a_reg     <= dy64;
                                mul_b_reg     <= xm;
                                mul_start_reg <= 1'b1;
                                state_reg     <= S_ACC;
                            end
                        end
                        bnb_pkg::CMD_FINALIZE: begin
                            res_reg.kind <= bnb_pkg::KIND_GRAD;
                            if (item_reg.ok) begin
                                mul_a_reg     <= ssum;
                                mul_b_reg     <= inv64;
                                mul_start_reg <= 1'b1;
                                state_reg     <= S_FIN;
                            end
                        end
                        default: begin
                            res_reg.kind <= bnb_pkg::KIND_DX;
                            if (item_reg.ok) begin
                                mul_start_reg <= 1'b1;
                                if (cfg.train_mode) begin
                                    mul_a_reg <= ssum;
                                    mul_b_reg <= inv64;
                                    state_reg <= S_DSC;
                                end else begin
                                    d_reg     <= dy64;
                                    mul_a_reg <= 64'($signed(gam_q));
                                    mul_b_reg <= inv64;
                                    state_reg <= S_G;
                                end
                            end
                        end
                    endcase
                end
                S_ACC: begin
                    if (mul_done) state_reg <= S_OUT;
                end
                S_FIN: begin
                    if (mul_done) begin
                        res_reg.grad_bias  <= sat32(bsum);
                        res_reg.grad_scale <= sat32(mul_res);
                        state_reg          <= S_OUT;
                    end
                end
                S_DSC: begin
                    if (mul_done) begin
                        mul_a_reg     <= xm;
                        mul_b_reg     <= mul_res;
                        mul_start_reg <= 1'b1;
                        state_reg     <= S_P1;
                    end
                end
                S_P1: begin
                    if (mul_done) begin
                        mul_a_reg     <= mul_res;
                        mul_b_reg     <= inv64;
                        mul_start_reg <= 1'b1;
                        state_reg     <= S_P2;
                    end
                end
                S_P2: begin
                    if (mul_done) begin
                        p2_reg        <= mul_res;
                        div_a_reg     <= bsum;
                        div_start_reg <= 1'b1;
                        state_reg     <= S_T1;
                    end
                end
                S_T1: begin
                    if (div_done) begin
                        t1_reg        <= div_q;
                        div_a_reg     <= p2_reg;
                        div_start_reg <= 1'b1;
                        state_reg     <= S_T2;
                    end
                end
                S_T2: begin
                    if (div_done) begin
                        d_reg         <= sat_sub(dy64, sat_add(t1_reg, div_q));
                        mul_a_reg     <= 64'($signed(gam_q));
                        mul_b_reg     <= inv64;
                        mul_start_reg <= 1'b1;
                        state_reg     <= S_G;
                    end
                end
                S_G: begin
                    if (mul_done) begin
                        mul_a_reg     <= d_reg;
                        mul_b_reg     <= mul_res;
                        mul_start_reg <= 1'b1;
                        state_reg     <= S_R;
                    end
                end
                S_R: begin
                    if (mul_done) begin
                        res_reg.grad_input <= sat32(mul_res);
                        state_reg          <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (!m_valid_reg || m_ready) begin
                        out_reg     <= res_reg;
                        m_valid_reg <= 1'b1;
                        state_reg   <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

endmodule

### src/batch_norm_backward.sv
// per transaction: load and bad channel need no arithmetic, accumulate and finalize one multiply,
// dx without train mode two multiplies, with it five multiplies and two divides
// throughput: one transaction at a time in the back end, set by the shared 32x32
// multiply sequence and the 64-step divider; a two-entry queue decouples input
// synchronous active-low reset clears queue, sequencer, accumulator valid bits and
// config (sample_count 1, train_mode 1); no clearing pass
module batch_norm_backward #(
    parameter int CHANNELS = bnb_pkg::CHANNELS_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_wr_en,
    input  logic [bnb_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [bnb_pkg::CFG_DATA_W-1:0]    cfg_wdata,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  bnb_pkg::in_item_t                 s_data,
    output logic                              m_valid,
    input  logic                              m_ready,
    output bnb_pkg::out_item_t                m_data
);

    bnb_pkg::cfg_t cfg_reg;
    logic          job_valid, job_pop;
    bnb_pkg::job_t job;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.sample_count <= 25'd1;
            cfg_reg.train_mode   <= 1'b1;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                bnb_pkg::CFG_SAMPLE_COUNT: cfg_reg.sample_count <= cfg_wdata;
                bnb_pkg::CFG_TRAIN_MODE:   cfg_reg.train_mode   <= cfg_wdata[0];
                default: begin
                end
            endcase
        end
    end

    bnb_front #(.CHANNELS(CHANNELS)) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .job_valid (job_valid),
        .job       (job),
        .job_pop   (job_pop)
    );

    bnb_back #(.CHANNELS(CHANNELS)) u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg_reg),
        .job_valid (job_valid),
        .job       (job),
        .job_pop   (job_pop),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

endmodule
